[src/swsnd_pkg.sv]
// ----------------------------------------------------------------------------
// swsnd_pkg: shared types and constants of the sliding window sender
// Field widths, request and result codes, and the result record type.
// ----------------------------------------------------------------------------
package swsnd_pkg;

    // Field widths fixed by the channel formats.
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 11;
    localparam int LIMIT_W = 9;
    localparam int SLOT8_W = 8;
    localparam int KIND_W  = 3;
    localparam int REQ_W   = 2;

    // Window limit handling.
    localparam int LIMIT_FLOOR = 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd150;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACKED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;

    // One result as held in the output register; the slot index is
    // derived from the sequence number at the port.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_res;

endpackage

[src/swsnd_req_if.sv]
// ----------------------------------------------------------------------------
// swsnd_req_if: request channel of the sliding window sender
// Valid/ready channel carrying one send, acknowledgement or timeout request.
// ----------------------------------------------------------------------------
interface swsnd_req_if;
    logic                          valid;
    logic                          ready;
    logic [swsnd_pkg::REQ_W-1:0]   req_type;
    logic [swsnd_pkg::SEQ_W-1:0]   ack_number;
    logic [15:0]                   payload_len;

    modport source (output valid, req_type, ack_number, payload_len, input ready);
    modport sink   (input valid, req_type, ack_number, payload_len, output ready);
endinterface

[src/swsnd_res_if.sv]
// ----------------------------------------------------------------------------
// swsnd_res_if: result channel of the sliding window sender
// Valid/ready channel carrying one result record.
// ----------------------------------------------------------------------------
interface swsnd_res_if;
    logic                           valid;
    logic                           ready;
    logic [swsnd_pkg::KIND_W-1:0]   result_kind;
    logic [swsnd_pkg::SEQ_W-1:0]    seq_number;
    logic [swsnd_pkg::SLOT8_W-1:0]  slot_index;
    logic [swsnd_pkg::LEN_W-1:0]    stored_len;
    logic                           last;

    modport source (output valid, result_kind, seq_number, slot_index, stored_len, last,
                    input ready);
    modport sink   (input valid, result_kind, seq_number, slot_index, stored_len, last,
                    output ready);
endinterface

[src/swsnd_cfg_if.sv]
// ----------------------------------------------------------------------------
// swsnd_cfg_if: configuration write channel of the sliding window sender
// Valid/ready channel carrying the window limit register value.
// ----------------------------------------------------------------------------
interface swsnd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [swsnd_pkg::LIMIT_W-1:0]  window_limit;

    modport source (output valid, window_limit, input ready);
    modport sink   (input valid, window_limit, output ready);
endinterface

[src/swsnd_ram.sv]
// ----------------------------------------------------------------------------
// swsnd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module swsnd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/swsnd_ctrl.sv]
// ----------------------------------------------------------------------------
// swsnd_ctrl: window sequencer of the sliding window sender
// Holds the sequence pointers, drives the slot length RAM and the output
// register, and steps through retransmit bursts one slot per cycle while the output is free.
// ----------------------------------------------------------------------------
module swsnd_ctrl #(
    parameter int WINDOW_SLOTS = 256,
    parameter int MAX_PAYLOAD  = 1024,
    parameter int RETX_BURST   = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [swsnd_pkg::LIMIT_W-1:0]       i_window_limit,
    swsnd_req_if.sink                           i_req,
    swsnd_res_if.source                         o_res,
    output logic                                o_ram_we,
    output logic [$clog2(WINDOW_SLOTS)-1:0]     o_ram_waddr,
    output logic [swsnd_pkg::LEN_W-1:0]         o_ram_wdata,
    output logic                                o_ram_re,
    output logic [$clog2(WINDOW_SLOTS)-1:0]     o_ram_raddr,
    input  logic [swsnd_pkg::LEN_W-1:0]         i_ram_rdata
);

    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int CNT_W  = $clog2(RETX_BURST + 1);
    localparam int SEQ_W  = swsnd_pkg::SEQ_W;
    localparam int LEN_W  = swsnd_pkg::LEN_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RETX = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [SEQ_W-1:0]    r_next, n_next;
    logic [SEQ_W-1:0]    r_oldest, n_oldest;
    logic [SEQ_W-1:0]    r_scan, n_scan;
    logic [CNT_W-1:0]    r_left, n_left;
    logic                r_out_valid, n_out_valid;
    swsnd_pkg::t_res     r_out, n_out;

    logic [SEQ_W-1:0]    w_dist;
    logic [SEQ_W-1:0]    w_lim_ext;
    logic [SEQ_W-1:0]    w_lim;
    logic                w_full;
    logic [LEN_W-1:0]    w_len;
    logic [SEQ_W-1:0]    w_d_ack;
    logic                w_ack_bad;
    logic [CNT_W-1:0]    w_burst;
    logic                w_out_free;
    logic                w_accept;
    logic [SEQ_W-1:0]    w_scan_inc;
    logic [SEQ_W-1:0]    w_out_slot;

    // The slot of a sequence number (slot count is a power of two).
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
        slot_of = seq[SLOT_W-1:0];
    endfunction

    // Window arithmetic. The outstanding span never exceeds the slot count,
    // so a slot is occupied exactly when its sequence lies in
    // [oldest, next); no per-slot occupancy flag is needed.
    always_comb begin
        w_dist    = r_next - r_oldest;
        w_lim_ext = SEQ_W'(i_window_limit);
        if (w_lim_ext < SEQ_W'(swsnd_pkg::LIMIT_FLOOR)) begin
            w_lim = SEQ_W'(swsnd_pkg::LIMIT_FLOOR);
        end else if (w_lim_ext > SEQ_W'(WINDOW_SLOTS)) begin
            w_lim = SEQ_W'(WINDOW_SLOTS);
        end else begin
            w_lim = w_lim_ext;
        end
        w_full    = !w_dist[SEQ_W-1] && (w_dist >= w_lim);
        w_len     = (i_req.payload_len > 16'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                           : i_req.payload_len[LEN_W-1:0];
        w_d_ack   = i_req.ack_number - r_oldest;
        w_ack_bad = (w_d_ack == '0) || w_d_ack[SEQ_W-1] || (w_d_ack > w_dist);
        w_burst   = (w_dist >= SEQ_W'(RETX_BURST)) ? CNT_W'(RETX_BURST)
                                                   : w_dist[CNT_W-1:0];
        w_scan_inc = r_scan + 1'b1;
    end

    // Handshake: one request at a time, taken in idle when the output slot is free.
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    // Next-state logic. RAM writes happen only in idle and reads only for
    // a retransmit burst, so the sequencer itself keeps the two apart.
    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_oldest    = r_oldest;
        n_scan      = r_scan;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        o_ram_we    = 1'b0;
        o_ram_waddr = slot_of(r_next);
        o_ram_wdata = w_len;
        o_ram_re    = 1'b0;
        o_ram_raddr = slot_of(r_scan);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.req_type)
                        swsnd_pkg::REQ_SEND: begin
                            n_out_valid = 1'b1;
                            n_out.kind  = w_full ? swsnd_pkg::KIND_FULL
                                                 : swsnd_pkg::KIND_SENT;
                            n_out.seq   = r_next;
                            n_out.len   = w_len;
                            n_out.last  = 1'b1;
                            if (!w_full) begin
                                o_ram_we = 1'b1;
                                n_next   = r_next + 1'b1;
                            end
                        end
                        swsnd_pkg::REQ_ACK: begin
                            n_out_valid = 1'b1;
                            n_out.kind  = w_ack_bad ? swsnd_pkg::KIND_IGNORED
                                                    : swsnd_pkg::KIND_ACKED;
                            n_out.seq   = i_req.ack_number;
                            n_out.len   = '0;
                            n_out.last  = 1'b1;
                            if (!w_ack_bad) begin
                                n_oldest = i_req.ack_number;
                            end
                        end
                        swsnd_pkg::REQ_TIMEOUT: begin
                            if (w_dist != '0) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = slot_of(r_oldest);
                                n_scan      = r_oldest;
                                n_left      = w_burst;
                                n_state     = S_RETX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RETX: begin
                // Emit the slot fetched by the last read and fetch the following one.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = swsnd_pkg::KIND_RETX;
                    n_out.seq   = r_scan;
                    n_out.len   = i_ram_rdata;
                    n_out.last  = (r_left == CNT_W'(1));
                    n_scan      = w_scan_inc;
                    n_left      = r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = slot_of(w_scan_inc);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_oldest    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_oldest    <= n_oldest;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_out  <= n_out;
    end

    // Result port.
    assign w_out_slot        = SEQ_W'(slot_of(r_out.seq));
    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out.kind;
    assign o_res.seq_number  = r_out.seq;
    assign o_res.slot_index  = w_out_slot[swsnd_pkg::SLOT8_W-1:0];
    assign o_res.stored_len  = r_out.len;
    assign o_res.last        = r_out.last;

    // The outstanding span never goes negative nor beyond the slot count.
    a_span_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_dist[SEQ_W-1] && (w_dist <= SEQ_W'(WINDOW_SLOTS)))
        else $error("outstanding span out of range");

    // The slot RAM is never written and read in the same cycle.
    a_ram_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("slot RAM write and read overlap");

    // A burst in progress always has slots left to emit.
    a_burst_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RETX) |-> (r_left != '0))
        else $error("retransmit burst with no slots left");

    // An accepted send into an open window advances the next sequence.
    a_send_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.req_type == swsnd_pkg::REQ_SEND) && !w_full)
        |=> (r_next == $past(r_next) + 1'b1))
        else $error("send did not advance the sequence");

endmodule

[src/sliding_window_sender.sv]
// ----------------------------------------------------------------------------
// sliding_window_sender: go-back-N sender window bookkeeping
// Tracks next and oldest sequence numbers, keeps slot lengths in a RAM and
// reports send, acknowledgement and retransmit results.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  i_req   | in  | valid/ready        | req_type, ack_number, payload_len
//  o_res   | out | valid/ready        | result_kind, seq_number, slot_index,
//          |     |                    | stored_len, last
//  i_cfg   | in  | valid/ready (=1)   | window_limit
//
// A send or acknowledgement request yields a single result, which is
// in the output register the cycle after acceptance.
// A timeout yields N = min(RETX_BURST, outstanding) retransmit results,
// each first read from the slot length RAM, whose read data is registered.
// Reset is synchronous; it clears the pointers and the output valid flag and
// needs no clearing pass, since occupancy follows from the pointers.
// A stalled result port holds requests off: while a result waits in the
// output register unaccepted, no new request is taken.
module sliding_window_sender #(
    parameter int WINDOW_SLOTS = 256,
    parameter int MAX_PAYLOAD  = 1024,
    parameter int RETX_BURST   = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swsnd_req_if.sink     i_req,
    swsnd_res_if.source   o_res,
    swsnd_cfg_if.sink     i_cfg
);

    localparam int SLOT_W = $clog2(WINDOW_SLOTS);

    logic [swsnd_pkg::LIMIT_W-1:0] r_window_limit;
    logic                          w_ram_we;
    logic [SLOT_W-1:0]             w_ram_waddr;
    logic [swsnd_pkg::LEN_W-1:0]   w_ram_wdata;
    logic                          w_ram_re;
    logic [SLOT_W-1:0]             w_ram_raddr;
    logic [swsnd_pkg::LEN_W-1:0]   w_ram_rdata;

    // Window limit register; always ready for a write.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit <= swsnd_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_window_limit <= i_cfg.window_limit;
        end
    end

    // Slot length store.
    swsnd_ram #(
        .WIDTH (swsnd_pkg::LEN_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Window sequencer.
    swsnd_ctrl #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .RETX_BURST   (RETX_BURST)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_limit (r_window_limit),
        .i_req          (i_req),
        .o_res          (o_res),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_re       (w_ram_re),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata)
    );

endmodule
